### design/aes128_pkg.sv
// Shared types, constants and byte functions for the AES-128 encryption core.
package aes128_pkg;

    typedef logic [127:0] block_t;
    typedef logic [3:0]   round_t;
    typedef logic [1:0]   cfg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_ROUND
    } fsm_t;

    localparam round_t     NUM_ROUNDS   = 4'd10;
    localparam round_t     FIRST_ROUND  = 4'd1;
    localparam logic [7:0] RCON_INIT    = 8'h01;
    localparam logic [7:0] GF_POLY      = 8'h1b;
    localparam cfg_index_t CFG_KEY_HIGH = 2'd0;
    localparam cfg_index_t CFG_KEY_LOW  = 2'd1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

### design/aes128_round.sv
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aes128_round (
    input  aes128_pkg::block_t blk_in,
    input  aes128_pkg::block_t rkey,
    input  logic               last,
    output aes128_pkg::block_t blk_out
);
    import aes128_pkg::*;

    logic [7:0] s   [16];
    logic [7:0] t   [16];
    logic [7:0] m   [16];
    logic [7:0] col [4];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = blk_in[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4 * c] = sbox(s[r + 4 * ((c + r) & 3)]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            col[c] = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
            for (int r = 0; r < 4; r++) begin
                m[4 * c + r] = t[4 * c + r] ^ col[c]
                             ^ gf_double(t[4 * c + r] ^ t[4 * c + ((r + 1) & 3)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            blk_out[127 - 8 * i -: 8] = (last ? t[i] : m[i]) ^ rkey[127 - 8 * i -: 8];
        end
    end

endmodule

### design/aes128_key_step.sv
// Round key expansion step: derives the next AES-128 round key.
module aes128_key_step (
    input  aes128_pkg::block_t key_in,
    input  logic [7:0]         rcon,
    output aes128_pkg::block_t key_out
);
    import aes128_pkg::*;

    logic [31:0] w  [4];
    logic [31:0] wn [4];
    logic [31:0] g;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w[i] = key_in[127 - 32 * i -: 32];
        end
        // RotWord + SubWord + Rcon on the last word
        g = {sbox(w[3][23:16]) ^ rcon, sbox(w[3][15:8]),
             sbox(w[3][7:0]), sbox(w[3][31:24])};
        wn[0] = w[0] ^ g;
        for (int i = 1; i < 4; i++) begin
            wn[i] = w[i] ^ wn[i - 1];
        end
        for (int i = 0; i < 4; i++) begin
            key_out[127 - 32 * i -: 32] = wn[i];
        end
    end

endmodule

### design/aes128_block_encrypt.sv
// AES-128 block encryption core: key registers, round sequencer, output register.
//
//  channel   ports                             direction  meaning
//  config    cfg_valid/cfg_ready, cfg_index,   in         key_high (0), key_low (1)
//            cfg_data
//  input     s_valid/s_ready, s_plain_high,    in         plaintext block
//            s_plain_low
//  result    m_valid/m_ready, m_cipher_high,   out        ciphertext block
//            m_cipher_low
//
//  A block is taken only when idle: the acceptance cycle loads the initial key addition,
//  then the single round unit and key step unit are reused for ten rounds.
//  The result sits in an output register; a new block is taken while it waits.
//  If the output register is still full after round ten, the core holds there.
//  Synchronous active-low reset clears the sequencer, valid flag and both keys.
module aes128_block_encrypt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  aes128_pkg::cfg_index_t cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [63:0]            s_plain_high,
    input  logic [63:0]            s_plain_low,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [63:0]            m_cipher_high,
    output logic [63:0]            m_cipher_low
);
    import aes128_pkg::*;

    fsm_t       fsm_reg,   fsm_next;
    round_t     round_reg, round_next;
    logic [7:0] rcon_reg,  rcon_next;
    block_t     blk_reg,   blk_next;
    block_t     rkey_reg,  rkey_next;
    block_t     out_reg,   out_next;
    logic       m_valid_reg, m_valid_next;
    logic [63:0] key_high_reg, key_low_reg;

    block_t round_out;
    block_t key_out;
    logic   last_round;
    logic   out_free;

    assign cfg_ready  = 1'b1;
    assign last_round = (round_reg == NUM_ROUNDS);
    assign out_free   = !m_valid_reg || m_ready;

    aes128_key_step u_key_step (
        .key_in  (rkey_reg),
        .rcon    (rcon_reg),
        .key_out (key_out)
    );

    aes128_round u_round (
        .blk_in  (blk_reg),
        .rkey    (key_out),
        .last    (last_round),
        .blk_out (round_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_KEY_HIGH) begin
                key_high_reg <= cfg_data;
            end
            if (cfg_index == CFG_KEY_LOW) begin
                key_low_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= ST_IDLE;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rcon_reg <= rcon_next;
        blk_reg  <= blk_next;
        rkey_reg <= rkey_next;
        out_reg  <= out_next;
    end

    always_comb begin
        fsm_next     = fsm_reg;
        round_next   = round_reg;
        rcon_next    = rcon_reg;
        blk_next     = blk_reg;
        rkey_next    = rkey_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = (fsm_reg == ST_IDLE);
        unique case (fsm_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    blk_next   = {s_plain_high, s_plain_low} ^ {key_high_reg, key_low_reg};
                    rkey_next  = {key_high_reg, key_low_reg};
                    rcon_next  = RCON_INIT;
                    round_next = FIRST_ROUND;
                    fsm_next   = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (!last_round) begin
                    blk_next   = round_out;
                    rkey_next  = key_out;
                    rcon_next  = gf_double(rcon_reg);
                    round_next = round_reg + FIRST_ROUND;
                end else if (out_free) begin
                    out_next     = round_out;
                    m_valid_next = 1'b1;
                    fsm_next     = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_cipher_high = out_reg[127:64];
    assign m_cipher_low  = out_reg[63:0];

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && round_reg == FIRST_ROUND)
        else $error("core not busy after input transaction");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fsm_reg == ST_ROUND |-> round_reg >= FIRST_ROUND && round_reg <= NUM_ROUNDS)
        else $error("round counter out of range");

    a_rcon_first: assert property (@(posedge aclk) disable iff (!aresetn)
        fsm_reg == ST_ROUND && round_reg == FIRST_ROUND |-> rcon_reg == RCON_INIT)
        else $error("round constant not initialized");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        fsm_reg == ST_ROUND && last_round && out_free |=> m_valid && s_ready)
        else $error("result not loaded after last round");

endmodule
